[sv/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types and constants for the monochrome page frame store.
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_INVERT = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [8:0] x_coord;
        logic signed [8:0] y_coord;
        logic              write_value;
        logic [7:0]        rect_width;
        logic [7:0]        rect_height;
    } mpf_req_t;

endpackage

[sv/mpf_front.sv]
// ----------------------------------------------------------------------------
// mpf_front
// Accepts requests and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module mpf_front
    import mpf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  mpf_req_t in_req,
    output logic     q_valid,
    input  logic     q_ready,
    output mpf_req_t q_req
);

    mpf_req_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !in_ready) else $error("full queue accepts");
    a_pop_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push && count_reg == 2'd1) |=> !q_valid)
        else $error("queue not empty after last pop");
`endif

endmodule

[sv/mpf_engine.sv]
// ----------------------------------------------------------------------------
// mpf_engine
// Executes requests on the byte store: pixel read/write, rectangle inversion
// byte by byte, clear, and the clearing pass after reset.
// ----------------------------------------------------------------------------
module mpf_engine
    import mpf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic [7:0] cfg_width,
    input  logic [6:0] cfg_height,
    input  logic     q_valid,
    output logic     q_ready,
    input  mpf_req_t q_req,
    output logic     m_valid,
    input  logic     m_ready,
    output logic     m_read_pixel,
    output logic     m_in_bounds
);

    localparam int STRIPS = (MAX_HEIGHT + 7) / 8;
    localparam int DEPTH  = MAX_WIDTH * STRIPS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = $clog2(STRIPS + 1);
    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_WRITE = 6'b001000,
        S_RESP  = 6'b010000,
        S_WALK  = 6'b100000
    } state_t;

    function automatic logic [7:0] mem_rd_bit(input logic [7:0] d, input logic [7:0] m);
        mem_rd_bit = d & m;
    endfunction

    state_t state_reg, state_next;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // effective geometry
    logic [XW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [SW-1:0] strip;
    assign eff_w = ({1'b0, cfg_width} > 9'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(cfg_width);
    assign eff_h = (7'(HW'(cfg_height)) != cfg_height
                    || HW'(cfg_height) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                       : HW'(cfg_height);
    assign strip = (eff_h == '0) ? '0 : SW'(((eff_h - 1'b1) >> 3) + 1'b1);

    mpf_req_t   req_reg;
    logic       rd_reg, ib_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0] mask_reg;
    logic       inv_reg;      // walk inverts (vs clears)
    // walk counters: column and strip
    logic signed [10:0] col_reg, col_end_reg;
    logic [SW-1:0] sidx_reg, s_first_reg, s_last_reg;
    logic signed [10:0] ylo_reg, yhi_reg;   // clipped row range [lo, hi]
    logic [AW:0] mul_reg;

    logic signed [10:0] qx, qy;
    logic pix_in;
    assign qx = 11'(q_req.x_coord);
    assign qy = 11'(q_req.y_coord);
    assign pix_in = (qx >= 0) && (qy >= 0) && (qx < 11'(eff_w)) && (qy < 11'(eff_h));

    // rectangle clipping
    logic signed [10:0] rx1, ry1, rx0c, ry0c, rx1c, ry1c;
    assign rx1  = qx + 11'(q_req.rect_width);
    assign ry1  = qy + 11'(q_req.rect_height);
    assign rx0c = (qx < 0) ? 11'sd0 : qx;
    assign ry0c = (qy < 0) ? 11'sd0 : qy;
    assign rx1c = (rx1 > $signed(11'(eff_w))) ? 11'(eff_w) : rx1;
    assign ry1c = (ry1 > $signed(11'(eff_h))) ? 11'(eff_h) : ry1;

    // byte mask for strip in walk
    logic signed [10:0] blo, bhi, rlo, rhi;
    logic [7:0] wmask;
    always_comb begin
        blo = 11'(sidx_reg) <<< 3;
        bhi = blo + 11'sd7;
        rlo = (ylo_reg > blo) ? ylo_reg : blo;
        rhi = (yhi_reg < bhi) ? yhi_reg : bhi;
        wmask = 8'hFF;
        if (inv_reg) begin
            wmask = (8'hFF >> rlo[2:0]) & (8'hFF << (3'd7 - rhi[2:0]));
        end
    end

    logic [AW:0] walk_addr;
    assign walk_addr = mul_reg + (AW+1)'(sidx_reg);

    logic [AW-1:0] pix_addr;
    assign pix_addr = AW'(((AW+1)'(qy[9:0] >> 3)) + (AW+1)'(qx[XW-1:0]) * (AW+1)'(strip));

    logic walk_last_s, walk_last_c;
    assign walk_last_s = (sidx_reg == s_last_reg);
    assign walk_last_c = (col_reg + 11'sd1 >= col_end_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:  if (addr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (q_valid) begin
                    case (q_req.req_type)
                        REQ_WRITE, REQ_READ: state_next = pix_in ? S_READ : S_RESP;
                        REQ_INVERT: state_next = (rx0c < rx1c && ry0c < ry1c) ? S_WALK : S_RESP;
                        default: state_next = (strip != '0 && eff_w != '0) ? S_WALK : S_RESP;
                    endcase
                end
            end
            S_READ:  state_next = (req_reg.req_type == REQ_WRITE) ? S_WRITE : S_RESP;
            S_WRITE: state_next = S_RESP;
            S_RESP:  if (m_ready) state_next = S_IDLE;
            S_WALK:  if (!inv_reg && walk_last_s && walk_last_c) state_next = S_RESP;
                     else if (inv_reg && walk_last_s && walk_last_c && mask_reg[0])
                         state_next = S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_RESP);
    assign m_read_pixel = rd_reg;
    assign m_in_bounds  = ib_reg;

    // memory port: one read, one write per cycle
    logic       we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0] wdata;
    always_comb begin
        we = 1'b0; waddr = addr_reg; wdata = 8'h00; raddr = addr_reg;
        case (state_reg)
            S_INIT: we = 1'b1;
            S_IDLE: raddr = pix_addr;
            S_WRITE: begin
                we = 1'b1;
                wdata = req_reg.write_value ? (rdata_reg | mask_reg) : (rdata_reg & ~mask_reg);
            end
            S_WALK: begin
                raddr = AW'(walk_addr);
                if (inv_reg) begin
                    // mask_reg[0] marks the write phase of a byte
                    we = mask_reg[0];
                    wdata = rdata_reg ^ mask_reg[7:0] ^ {7'd0, 1'b0};
                end else begin
                    we = 1'b1; waddr = AW'(walk_addr);
                end
            end
            default: ;
        endcase
    end

    // inversion uses a separate held mask
    logic [7:0] imask_reg;
    logic [AW-1:0] iaddr_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            if (state_reg == S_WALK && inv_reg) mem[iaddr_reg] <= rdata_reg ^ imask_reg;
            else mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            mask_reg  <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_INIT: addr_reg <= addr_reg + 1'b1;
                S_IDLE: if (q_valid) begin
                    req_reg  <= q_req;
                    rd_reg   <= 1'b0;
                    ib_reg   <= (q_req.req_type == REQ_WRITE || q_req.req_type == REQ_READ)
                                && pix_in;
                    addr_reg <= pix_addr;
                    mask_reg <= (q_req.req_type == REQ_INVERT) ? 8'h00 : (8'h80 >> qy[2:0]);
                    inv_reg  <= (q_req.req_type == REQ_INVERT);
                    if (q_req.req_type == REQ_INVERT) begin
                        col_reg     <= rx0c;
                        col_end_reg <= rx1c;
                        ylo_reg     <= ry0c;
                        yhi_reg     <= ry1c - 11'sd1;
                        s_first_reg <= SW'(ry0c >>> 3);
                        s_last_reg  <= SW'((ry1c - 11'sd1) >>> 3);
                        sidx_reg    <= SW'(ry0c >>> 3);
                        mul_reg     <= (AW+1)'(rx0c[XW-1:0]) * (AW+1)'(strip);
                    end else begin
                        col_reg     <= '0;
                        col_end_reg <= 11'(eff_w);
                        ylo_reg     <= '0;
                        yhi_reg     <= 11'(eff_h) - 11'sd1;
                        s_first_reg <= '0;
                        s_last_reg  <= strip - 1'b1;
                        sidx_reg    <= '0;
                        mul_reg     <= '0;
                    end
                end
                S_READ: rd_reg <= (req_reg.req_type == REQ_READ) && |(mem_rd_bit(rdata_reg, mask_reg));
                S_WALK: begin
                    if (!inv_reg || mask_reg[0]) begin
                        if (walk_last_s) begin
                            sidx_reg <= s_first_reg;
                            col_reg  <= col_reg + 11'sd1;
                            mul_reg  <= mul_reg + (AW+1)'(strip);
                        end else begin
                            sidx_reg <= sidx_reg + 1'b1;
                        end
                    end
                    if (inv_reg) begin
                        mask_reg  <= {7'd0, ~mask_reg[0]};
                        imask_reg <= wmask;
                        iaddr_reg <= AW'(walk_addr);
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_pixel)))
        else $error("response dropped");
    a_busy_noaccept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !q_ready) else $error("accept while busy");
    a_read_ib: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_pixel) |-> m_in_bounds) else $error("pixel without bounds");
`endif

endmodule

[sv/mono_page_framebuffer.sv]
// From request accept to result valid: an out-of-bounds pixel goes from idle straight to
// the response state, a pixel read passes the read state, a pixel write the read and write
// states; the result then waits for its handshake. Inversion reads, then writes, each
// touched byte; clear writes each mapped byte. The engine takes a new request only when idle.
// Reset: aresetn synchronous active low; a clearing pass over all
// MAX_WIDTH*ceil(MAX_HEIGHT/8) store bytes zeroes the store before any request is taken.
// ----------------------------------------------------------------------------
// mono_page_framebuffer
// Vertical-byte monochrome frame store with APB geometry registers.
// ----------------------------------------------------------------------------
module mono_page_framebuffer
    import mpf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic signed [8:0] s_x_coord,
    input  logic signed [8:0] s_y_coord,
    input  logic        s_write_value,
    input  logic [7:0]  s_rect_width,
    input  logic [7:0]  s_rect_height,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_read_pixel,
    output logic        m_in_bounds
);

    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic       q_valid, q_ready;
    mpf_req_t   in_req, q_req;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd128;
            height_reg <= 7'd64;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[7:0];
                REG_HEIGHT: height_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[2])
            REG_WIDTH: prdata = {24'd0, width_reg};
            default:   prdata = {25'd0, height_reg};
        endcase
    end

    assign in_req = '{req_type: s_req_type, x_coord: s_x_coord, y_coord: s_y_coord,
                      write_value: s_write_value, rect_width: s_rect_width,
                      rect_height: s_rect_height};

    mpf_front u_front (
        .aclk, .aresetn,
        .in_valid (s_valid), .in_ready (s_ready), .in_req (in_req),
        .q_valid, .q_ready, .q_req
    );

    mpf_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_engine (
        .aclk, .aresetn,
        .cfg_width (width_reg), .cfg_height (height_reg),
        .q_valid, .q_ready, .q_req,
        .m_valid, .m_ready, .m_read_pixel, .m_in_bounds
    );

endmodule

[tb/tb_mono_page_framebuffer.sv]
// ----------------------------------------------------------------------------
// tb_mono_page_framebuffer
// Drives pixel writes, reads, rectangle inversions and clears into the frame
// store under several surface geometries, predicts every result against a
// private copy of the pixel store, and checks results in order.
// ----------------------------------------------------------------------------
module tb_mono_page_framebuffer;
    import mpf_pkg::*;

    localparam int STORE_BYTES = DEF_MAX_WIDTH * ((DEF_MAX_HEIGHT + 7) / 8);
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic read_pixel;
        logic in_bounds;
    } pix_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic signed [8:0] s_x_coord = '0, s_y_coord = '0;
    logic s_write_value = 1'b0;
    logic [7:0] s_rect_width = '0, s_rect_height = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_read_pixel, m_in_bounds;

    mono_page_framebuffer i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mpf_req_t    pending_reqs[$];
    pix_result_t expected_results[$];
    logic [7:0]  shadow_store[STORE_BYTES];
    int unsigned geo_width = 128, geo_height = 64;
    int          fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0, take_gap = 0;
    bit          hold_sender = 1'b0;
    bit          in_taken = 1'b0, out_taken = 1'b0;

    function automatic int unsigned strip_of();
        int unsigned h;
        h = geo_height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : geo_height;
        return h == 0 ? 0 : (h - 1) / 8 + 1;
    endfunction

    function automatic bit on_surface(int x, int y);
        int unsigned w, h;
        w = geo_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : geo_width;
        h = geo_height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : geo_height;
        return x >= 0 && y >= 0 && x < int'(w) && y < int'(h);
    endfunction

    function automatic int unsigned addr_of(int x, int y);
        int unsigned a;
        a = y / 8 + x * strip_of();
        return a < STORE_BYTES ? a : 0;
    endfunction

    function automatic pix_result_t apply_request(mpf_req_t r);
        pix_result_t res;
        int x, y, a, n;
        res = '0;
        x = r.x_coord;
        y = r.y_coord;
        case (r.req_type)
            REQ_WRITE: begin
                if (on_surface(x, y)) begin
                    a = addr_of(x, y);
                    if (r.write_value) shadow_store[a][7 - y % 8] = 1'b1;
                    else shadow_store[a][7 - y % 8] = 1'b0;
                    res.in_bounds = 1'b1;
                end
            end
            REQ_READ: begin
                if (on_surface(x, y)) begin
                    res.read_pixel = shadow_store[addr_of(x, y)][7 - y % 8];
                    res.in_bounds = 1'b1;
                end
            end
            REQ_INVERT: begin
                for (int xi = x; xi < x + int'(r.rect_width); xi++)
                    for (int yi = y; yi < y + int'(r.rect_height); yi++)
                        if (on_surface(xi, yi)) begin
                            a = addr_of(xi, yi);
                            shadow_store[a][7 - yi % 8] = ~shadow_store[a][7 - yi % 8];
                        end
            end
            default: begin
                n = strip_of() * (geo_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : geo_width);
                if (n > STORE_BYTES) n = STORE_BYTES;
                for (int i = 0; i < n; i++) shadow_store[i] = '0;
            end
        endcase
        return res;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                in_taken = 1'b0;
                s_valid <= 1'b0;
                send_gap = $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end else if (!s_valid && !hold_sender && pending_reqs.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    mpf_req_t r;
                    r = pending_reqs.pop_front();
                    s_req_type <= r.req_type;
                    s_x_coord <= r.x_coord;
                    s_y_coord <= r.y_coord;
                    s_write_value <= r.write_value;
                    s_rect_width <= r.rect_width;
                    s_rect_height <= r.rect_height;
                    s_valid <= 1'b1;
                end
            end
            if (out_taken) begin
                out_taken = 1'b0;
                m_ready <= 1'b0;
                take_gap = $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0) take_gap = 0;
            end else if (take_gap > 0) begin
                take_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_valid && s_ready) begin
            mpf_req_t r;
            r = '{s_req_type, s_x_coord, s_y_coord, s_write_value,
                  s_rect_width, s_rect_height};
            expected_results.push_back(apply_request(r));
            in_taken = 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            out_taken = 1'b1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result read_pixel=%0b in_bounds=%0b",
                         $time, m_read_pixel, m_in_bounds);
                fail_count++;
            end else begin
                pix_result_t e;
                e = expected_results.pop_front();
                if (e.read_pixel !== m_read_pixel) begin
                    $display("%0t: read_pixel expected %0b actual %0b",
                             $time, e.read_pixel, m_read_pixel);
                    fail_count++;
                end
                if (e.in_bounds !== m_in_bounds) begin
                    $display("%0t: in_bounds expected %0b actual %0b",
                             $time, e.in_bounds, m_in_bounds);
                    fail_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** mono_page_framebuffer: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (2100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == 3'd4 * REG_WIDTH) geo_width = data[7:0];
        else geo_height = data[6:0];
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic push_req(logic [1:0] t, int x, int y, bit v, int rw, int rh);
        mpf_req_t r;
        r.req_type = t;
        r.x_coord = x[8:0];
        r.y_coord = y[8:0];
        r.write_value = v;
        r.rect_width = rw[7:0];
        r.rect_height = rh[7:0];
        pending_reqs.push_back(r);
    endtask

    task automatic push_random(int count);
        int unsigned w, h;
        w = geo_width > 0 ? geo_width : 1;
        h = geo_height > 0 ? geo_height : 1;
        for (int i = 0; i < count; i++) begin
            int k, x, y;
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                x = $urandom_range(0, 511) - 256;
                y = $urandom_range(0, 511) - 256;
            end else begin
                x = $urandom_range(0, w + 1) - 1;
                y = $urandom_range(0, h + 1) - 1;
            end
            if (k < 40)
                push_req(REQ_WRITE, x, y, $urandom_range(0, 1), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            else if (k < 85)
                push_req(REQ_READ, x, y, $urandom_range(0, 1), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            else if (k < 98)
                push_req(REQ_INVERT, x - $urandom_range(0, 8), y - $urandom_range(0, 8),
                         $urandom_range(0, 1),
                         $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 20),
                         $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 20));
            else
                push_req(REQ_CLEAR, x, y, $urandom_range(0, 1), $urandom_range(0, 255),
                         $urandom_range(0, 255));
        end
    endtask

    initial begin
        for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_req(REQ_READ, 0, 0, 0, 0, 0);
        push_req(REQ_WRITE, 0, 0, 1, 255, 255);
        push_req(REQ_WRITE, 127, 63, 1, 0, 0);
        push_req(REQ_WRITE, 128, 0, 1, 0, 0);
        push_req(REQ_WRITE, 0, 64, 1, 0, 0);
        push_req(REQ_WRITE, -1, -256, 1, 0, 0);
        push_req(REQ_READ, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 127, 63, 0, 0, 0);
        push_req(REQ_READ, 255, 255, 0, 0, 0);
        push_req(REQ_READ, -256, 3, 0, 0, 0);
        push_req(REQ_INVERT, 3, 5, 0, 0, 10);
        push_req(REQ_INVERT, 3, 5, 0, 10, 0);
        push_req(REQ_INVERT, -5, -7, 1, 20, 30);
        push_req(REQ_INVERT, 120, 56, 0, 255, 255);
        push_req(REQ_INVERT, 8, 8, 0, 4, 16);
        push_req(REQ_READ, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 10, 10, 0, 0, 0);
        push_req(REQ_WRITE, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 0, 0, 0, 0, 0);
        push_req(REQ_CLEAR, 0, 0, 0, 0, 0);
        push_req(REQ_READ, 127, 63, 0, 0, 0);
        push_random(200);
        wait_drained();

        hold_sender = 1'b1;
        push_random(20);
        repeat (40) @(posedge aclk);
        hold_sender = 1'b0;
        wait_drained();

        write_reg(3'd4 * REG_WIDTH, 32'd1);
        write_reg(3'd4 * REG_HEIGHT, 32'd1);
        push_random(100);
        wait_drained();

        write_reg(3'd4 * REG_WIDTH, 32'd37);
        write_reg(3'd4 * REG_HEIGHT, 32'd13);
        push_random(200);
        wait_drained();

        write_reg(3'd4 * REG_WIDTH, 32'd0);
        write_reg(3'd4 * REG_HEIGHT, 32'd20);
        push_random(40);
        wait_drained();

        write_reg(3'd4 * REG_WIDTH, 32'd255);
        write_reg(3'd4 * REG_HEIGHT, 32'd127);
        push_random(200);
        wait_drained();

        write_reg(3'd4 * REG_WIDTH, 32'd64);
        write_reg(3'd4 * REG_HEIGHT, 32'd0);
        push_random(40);
        wait_drained();

        write_reg(3'd4 * REG_WIDTH, 32'd128);
        write_reg(3'd4 * REG_HEIGHT, 32'd64);
        push_random(330);
        wait_drained();

        if (fail_count == 0) $display("** mono_page_framebuffer: PASSED **");
        else $display("** mono_page_framebuffer: FAILED **");
        $finish;
    end
endmodule
